// ===== src/lrs_pkg.sv =====
// Shared constants, codes and word types for the latching relay sequencer.
package lrs_pkg;

    // Sizing
    localparam int CHANNELS    = 6;
    localparam int QUEUE_DEPTH = 10;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PFX_W       = $clog2(CHANNELS + 1);
    localparam int SUM_W       = $clog2(2 * QUEUE_DEPTH + CHANNELS + 1);

    // Operation codes
    localparam logic OP_MSG  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Channel state codes
    localparam logic [1:0] ST_OFF     = 2'd0;
    localparam logic [1:0] ST_ON      = 2'd1;
    localparam logic [1:0] ST_UNAVAIL = 2'd3;

    // LED byte constants
    localparam logic [7:0] LED_POWER  = 8'd64;
    localparam logic [7:0] LED_REPORT = 8'd128;
    localparam logic [7:0] LED_ERROR  = 8'd63;

    // Reset value of the instance register
    localparam logic [7:0] INSTANCE_RESET = 8'd255;

    typedef struct packed {
        logic        op;
        logic [7:0]  msg_instance;
        logic [11:0] requested_states;
    } in_word_t;

    typedef struct packed {
        logic [5:0]  relay_enable;
        logic        coil_set;
        logic [11:0] channel_states;
        logic [7:0]  led_pattern;
        logic        queue_dropped;
        logic        status_report;
        logic [3:0]  queue_level;
    } out_word_t;

    // One pending coil operation
    typedef struct packed {
        logic [CH_W-1:0] chan;
        logic            pol;
    } entry_t;

    // Requests from the core to the queue
    typedef struct packed {
        logic [CHANNELS-1:0] push;
        logic [CHANNELS-1:0] pol;
        logic                pop;
    } q_req_t;

    // Status from the queue to the core
    typedef struct packed {
        entry_t           head_entry;
        logic             pop_ok;
        logic [CNT_W-1:0] count_next;
        logic             any_push;
        logic             any_drop;
        logic             last_drop;
    } q_stat_t;

endpackage

// ===== src/lrs_queue.sv =====
// Operation queue: several pushes per message word, one pop per tick.
module lrs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  lrs_pkg::q_req_t req,
    output lrs_pkg::q_stat_t stat
);

    logic [lrs_pkg::PTR_W-1:0] head_reg;
    logic [lrs_pkg::PTR_W-1:0] head_next;
    logic [lrs_pkg::CNT_W-1:0] count_reg;
    logic [lrs_pkg::CNT_W-1:0] count_next;
    lrs_pkg::entry_t           mem_reg [lrs_pkg::QUEUE_DEPTH];

    logic [lrs_pkg::PFX_W-1:0] pfx;
    logic [lrs_pkg::SUM_W-1:0] fill;
    logic [lrs_pkg::SUM_W-1:0] slot;
    logic [lrs_pkg::CNT_W-1:0] n_acc;
    logic [lrs_pkg::CHANNELS-1:0] acc;
    logic [lrs_pkg::PTR_W-1:0] addr [lrs_pkg::CHANNELS];
    logic                      any_drop;
    logic                      last_drop;
    logic                      pop_ok;

    // Place each requested entry at tail plus the number of earlier requests
    always_comb
    begin
        pfx       = '0;
        n_acc     = '0;
        acc       = '0;
        any_drop  = 1'b0;
        last_drop = 1'b0;
        fill      = '0;
        slot      = '0;
        for (int c = 0; c < lrs_pkg::CHANNELS; c++)
        begin
            fill = lrs_pkg::SUM_W'(count_reg) + lrs_pkg::SUM_W'(pfx);
            slot = fill + lrs_pkg::SUM_W'(head_reg);
            if (slot >= lrs_pkg::SUM_W'(lrs_pkg::QUEUE_DEPTH))
            begin
                slot = slot - lrs_pkg::SUM_W'(lrs_pkg::QUEUE_DEPTH);
            end
            addr[c] = slot[lrs_pkg::PTR_W-1:0];
            if (req.push[c])
            begin
                if (fill < lrs_pkg::SUM_W'(lrs_pkg::QUEUE_DEPTH))
                begin
                    acc[c]    = 1'b1;
                    n_acc     = n_acc + lrs_pkg::CNT_W'(1);
                    last_drop = 1'b0;
                end
                else
                begin
                    any_drop  = 1'b1;
                    last_drop = 1'b1;
                end
                pfx = pfx + lrs_pkg::PFX_W'(1);
            end
        end
    end

    // Advance head and count
    always_comb
    begin
        pop_ok     = req.pop && (count_reg != '0);
        head_next  = head_reg;
        count_next = count_reg + n_acc;
        if (pop_ok)
        begin
            count_next = count_reg - lrs_pkg::CNT_W'(1);
            if (head_reg == lrs_pkg::PTR_W'(lrs_pkg::QUEUE_DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + lrs_pkg::PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Write accepted entries into their slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < lrs_pkg::QUEUE_DEPTH; i++)
        begin
            for (int c = 0; c < lrs_pkg::CHANNELS; c++)
            begin
                if (acc[c] && (addr[c] == lrs_pkg::PTR_W'(i)))
                begin
                    mem_reg[i] <= '{chan: lrs_pkg::CH_W'(c), pol: req.pol[c]};
                end
            end
        end
    end

    // Report to the core
    always_comb
    begin
        stat.head_entry = mem_reg[head_reg];
        stat.pop_ok     = pop_ok;
        stat.count_next = count_next;
        stat.any_push   = |req.push;
        stat.any_drop   = any_drop;
        stat.last_drop  = last_drop;
    end

endmodule

// ===== src/latching_relay_sequencer_core.sv =====
// Top level: input register, channel evaluation, held relay state and result register.
// The input register captures the accepted word, and the result register then takes the result
// word, with done raised alongside it.
// Throughput: one word per cycle; busy stays low, and the queue and relay state update on every word.
// The receiver cannot stall; each result is shown for exactly one cycle under done.
// Reset (rst_n low, asynchronous): queue empty, all channels unavailable, enables and
// polarity clear, LED override off, instance register 255.
module latching_relay_sequencer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lrs_pkg::in_word_t  in_word,
    output logic               done,
    output lrs_pkg::out_word_t result,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);

    logic                         in_vld_reg;
    lrs_pkg::in_word_t            in_reg;
    logic [7:0]                   instance_reg;
    logic [lrs_pkg::CHANNELS-1:0] enables_reg;
    logic [lrs_pkg::CHANNELS-1:0] enables_next;
    logic                         pol_reg;
    logic                         pol_next;
    logic [11:0]                  states_reg;
    logic [11:0]                  states_next;
    logic                         override_reg;
    logic                         override_next;
    logic                         done_reg;
    lrs_pkg::out_word_t           result_reg;
    lrs_pkg::out_word_t           result_next;

    lrs_pkg::q_req_t              q_req;
    lrs_pkg::q_stat_t             q_stat;
    logic                         msg_go;
    logic [1:0]                   r;
    logic [lrs_pkg::CHANNELS-1:0] on_bits;
    logic [7:0]                   led;

    assign busy = 1'b0;

    // Capture the incoming word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= in_word;
        end
    end

    // Hold the instance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            instance_reg <= lrs_pkg::INSTANCE_RESET;
        end
        else if (cfg_we)
        begin
            instance_reg <= cfg_wdata;
        end
    end

    // Decide which channels ask for a change
    always_comb
    begin
        msg_go = in_vld_reg && (in_reg.op == lrs_pkg::OP_MSG)
                 && (in_reg.msg_instance == instance_reg);
        q_req  = '0;
        r      = '0;
        for (int c = 0; c < lrs_pkg::CHANNELS; c++)
        begin
            r = in_reg.requested_states[2*c +: 2];
            q_req.push[c] = msg_go && (r == lrs_pkg::ST_OFF || r == lrs_pkg::ST_ON)
                            && (r != states_reg[2*c +: 2]);
            q_req.pol[c]  = r[0];
        end
        q_req.pop = in_vld_reg && (in_reg.op == lrs_pkg::OP_TICK);
    end

    lrs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (q_req),
        .stat  (q_stat)
    );

    // Run the popped coil operation and build the result word
    always_comb
    begin
        enables_next  = enables_reg;
        pol_next      = pol_reg;
        states_next   = states_reg;
        override_next = override_reg;
        if (q_req.pop)
        begin
            enables_next = '0;
        end
        if (q_stat.pop_ok)
        begin
            pol_next = q_stat.head_entry.pol;
            for (int c = 0; c < lrs_pkg::CHANNELS; c++)
            begin
                if (q_stat.head_entry.chan == lrs_pkg::CH_W'(c))
                begin
                    enables_next[c]      = 1'b1;
                    states_next[2*c +: 2] = {1'b0, q_stat.head_entry.pol};
                end
            end
        end
        if (q_stat.any_push)
        begin
            override_next = q_stat.last_drop;
        end
        for (int c = 0; c < lrs_pkg::CHANNELS; c++)
        begin
            on_bits[c] = (states_next[2*c +: 2] == lrs_pkg::ST_ON);
        end
        if (override_next)
        begin
            led = lrs_pkg::LED_ERROR;
        end
        else
        begin
            led = 8'(on_bits) | lrs_pkg::LED_POWER
                  | (q_stat.pop_ok ? lrs_pkg::LED_REPORT : 8'd0);
        end
        result_next.relay_enable   = 6'(enables_next);
        result_next.coil_set       = pol_next;
        result_next.channel_states = states_next;
        result_next.led_pattern    = led;
        result_next.queue_dropped  = q_stat.any_drop;
        result_next.status_report  = q_stat.pop_ok;
        result_next.queue_level    = 4'(q_stat.count_next);
    end

    // Hold relay state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enables_reg  <= '0;
            pol_reg      <= 1'b0;
            states_reg   <= {lrs_pkg::CHANNELS{lrs_pkg::ST_UNAVAIL}};
            override_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            enables_reg  <= enables_next;
            pol_reg      <= pol_next;
            states_reg   <= states_next;
            override_reg <= override_next;
            done_reg     <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    a_one_coil: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0(result.relay_enable))
        else $error("more than one coil enabled");

    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.queue_level <= 4'(lrs_pkg::QUEUE_DEPTH)))
        else $error("queue level above depth");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result word missing two cycles after accept");

    a_drop_led: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.queue_dropped) |-> (result.led_pattern == lrs_pkg::LED_ERROR))
        else $error("dropped entry without error pattern");

    a_report_led: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status_report)
            |-> (result.led_pattern[7] || result.led_pattern == lrs_pkg::LED_ERROR))
        else $error("report without report LED");

endmodule

// ===== tb/latching_relay_sequencer_core_tb.sv =====
// Testbench for the latching relay sequencer core: directed and random words against a predictor.
`timescale 1ns / 1ps

module latching_relay_sequencer_core_tb;

    localparam int SETTLE_CYCLES = 6;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    lrs_pkg::in_word_t  in_word   = '0;
    logic               done;
    lrs_pkg::out_word_t result;
    logic               cfg_we    = 1'b0;
    logic [7:0]         cfg_wdata = 8'd0;

    // Predictor state
    logic [7:0]  m_instance;
    logic [2:0]  pend_chan [lrs_pkg::QUEUE_DEPTH];
    logic        pend_pol  [lrs_pkg::QUEUE_DEPTH];
    int          pend_head;
    int          pend_count;
    logic [11:0] chan_state;
    logic [5:0]  coil_en;
    logic        coil_pol;
    logic        led_err;

    lrs_pkg::out_word_t expected_relay_words [$];
    lrs_pkg::out_word_t head_word;
    int                 mismatch_count = 0;
    bit                 idle_off       = 1'b0;

    latching_relay_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_word   (in_word),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Work out the result word of one accepted input word and advance the predictor
    function automatic lrs_pkg::out_word_t sequence_relays(input lrs_pkg::in_word_t w);
        lrs_pkg::out_word_t o;
        logic [1:0]         req;
        logic               dropped;
        logic               report;
        logic [5:0]         on_bits;
        int                 tail;
        int                 c;
        dropped = 1'b0;
        report  = 1'b0;
        if (w.op == lrs_pkg::OP_MSG)
        begin
            if (w.msg_instance == m_instance)
            begin
                for (c = 0; c < lrs_pkg::CHANNELS; c++)
                begin
                    req = w.requested_states[2*c +: 2];
                    if (req <= lrs_pkg::ST_ON && req != chan_state[2*c +: 2])
                    begin
                        if (pend_count < lrs_pkg::QUEUE_DEPTH)
                        begin
                            tail = (pend_head + pend_count) % lrs_pkg::QUEUE_DEPTH;
                            pend_chan[tail] = c[2:0];
                            pend_pol[tail]  = req[0];
                            pend_count++;
                            led_err = 1'b0;
                        end
                        else
                        begin
                            dropped = 1'b1;
                            led_err = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin
            // Drop every coil first, then fire at most one pending operation
            coil_en = '0;
            if (pend_count > 0)
            begin
                c = int'(pend_chan[pend_head]);
                coil_pol = pend_pol[pend_head];
                pend_head = (pend_head + 1) % lrs_pkg::QUEUE_DEPTH;
                pend_count--;
                coil_en[c] = 1'b1;
                chan_state[2*c +: 2] = coil_pol ? lrs_pkg::ST_ON : lrs_pkg::ST_OFF;
                report = 1'b1;
            end
        end
        for (c = 0; c < lrs_pkg::CHANNELS; c++)
            on_bits[c] = (chan_state[2*c +: 2] == lrs_pkg::ST_ON);
        o.relay_enable   = coil_en;
        o.coil_set       = coil_pol;
        o.channel_states = chan_state;
        if (led_err)
            o.led_pattern = lrs_pkg::LED_ERROR;
        else
            o.led_pattern = {2'b00, on_bits} | lrs_pkg::LED_POWER
                            | (report ? lrs_pkg::LED_REPORT : 8'd0);
        o.queue_dropped  = dropped;
        o.status_report  = report;
        o.queue_level    = pend_count[3:0];
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [11:0] exp_v,
                                        input logic [11:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Compare each result word with the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_relay_words.size() == 0)
            begin
                $error("result: word with none expected");
                mismatch_count++;
            end
            else
            begin
                head_word = expected_relay_words.pop_front();
                check_field("relay_enable", 12'(head_word.relay_enable),
                            12'(result.relay_enable));
                check_field("coil_set", 12'(head_word.coil_set), 12'(result.coil_set));
                check_field("channel_states", head_word.channel_states,
                            result.channel_states);
                check_field("led_pattern", 12'(head_word.led_pattern),
                            12'(result.led_pattern));
                check_field("queue_dropped", 12'(head_word.queue_dropped),
                            12'(result.queue_dropped));
                check_field("status_report", 12'(head_word.status_report),
                            12'(result.status_report));
                check_field("queue_level", 12'(head_word.queue_level),
                            12'(result.queue_level));
            end
        end
    end

    // Offer one word, hold it until accepted, then idle for a random gap that may be zero
    task automatic send_word(input lrs_pkg::in_word_t w);
        int gap;
        int r;
        start   <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_relay_words.push_back(sequence_relays(w));
        r = $urandom_range(0, 99);
        if (idle_off || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(input logic op, input logic [7:0] inst, input logic [11:0] req);
        lrs_pkg::in_word_t w;
        w.op               = op;
        w.msg_instance     = inst;
        w.requested_states = req;
        send_word(w);
    endtask

    // Drop start and wait for every expected word, then wait out SETTLE_CYCLES
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_relay_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_instance(input logic [7:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_instance = v;
    endtask

    // Reset defaults, instance mismatch, skipped requests and the undefined instance
    task automatic test_power_up();
        send_fields(lrs_pkg::OP_TICK, 8'h00, 12'h000);
        send_fields(lrs_pkg::OP_MSG,  8'h00, 12'h000);
        send_fields(lrs_pkg::OP_MSG,  8'hFF, 12'hAAA);
        send_fields(lrs_pkg::OP_MSG,  8'hFF, 12'hFFF);
        send_fields(lrs_pkg::OP_MSG,  8'hFF, 12'h555);
        send_fields(lrs_pkg::OP_TICK, 8'hFF, 12'hFFF);
        send_fields(lrs_pkg::OP_TICK, 8'h00, 12'h000);
    endtask

    // Fill the queue, overflow it, drain it and clear the error pattern
    task automatic test_queue_overflow();
        write_instance(8'h00);
        send_fields(lrs_pkg::OP_MSG,  8'hFF, 12'h000);
        send_fields(lrs_pkg::OP_MSG,  8'h00, 12'h000);
        send_fields(lrs_pkg::OP_MSG,  8'h00, 12'h555);
        send_fields(lrs_pkg::OP_MSG,  8'h00, 12'h9A6);
        repeat (4) send_fields(lrs_pkg::OP_TICK, 8'h00, 12'h000);
        send_fields(lrs_pkg::OP_MSG,  8'h00, 12'h001);
        repeat (7) send_fields(lrs_pkg::OP_TICK, 8'h5A, 12'hA5A);
        send_fields(lrs_pkg::OP_TICK, 8'h00, 12'h000);
    endtask

    // Random traffic for one instance setting; ticks take tick_pct percent of the words
    task automatic test_random_traffic(input logic [7:0] inst, input int n_words,
                                       input int tick_pct, input bit no_gaps);
        lrs_pkg::in_word_t w;
        logic [31:0]       rnd;
        int                i;
        int                c;
        write_instance(inst);
        idle_off = no_gaps;
        for (i = 0; i < n_words; i++)
        begin
            rnd = $urandom;
            w = rnd[$bits(lrs_pkg::in_word_t)-1:0];
            if ($urandom_range(0, 99) < tick_pct)
            begin
                w.op = lrs_pkg::OP_TICK;
            end
            else
            begin
                w.op = lrs_pkg::OP_MSG;
                if ($urandom_range(0, 99) < 85)
                    w.msg_instance = inst;
                // Keep most requests to on or off so the queue sees real work
                if ($urandom_range(0, 99) < 60)
                    for (c = 0; c < lrs_pkg::CHANNELS; c++)
                        w.requested_states[2*c+1] = 1'b0;
            end
            send_word(w);
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        m_instance = lrs_pkg::INSTANCE_RESET;
        pend_head  = 0;
        pend_count = 0;
        chan_state = {lrs_pkg::CHANNELS{lrs_pkg::ST_UNAVAIL}};
        coil_en    = '0;
        coil_pol   = 1'b0;
        led_err    = 1'b0;
        for (int k = 0; k < lrs_pkg::QUEUE_DEPTH; k++)
        begin
            pend_chan[k] = '0;
            pend_pol[k]  = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_queue_overflow();
        test_random_traffic(8'h00, 300, 40, 1'b0);
        test_random_traffic(8'hFF, 300, 60, 1'b0);
        test_random_traffic(8'($urandom), 300, 25, 1'b0);
        test_random_traffic(8'($urandom), 300, 50, 1'b1);
        test_random_traffic(8'($urandom), 300, 75, 1'b0);
        test_random_traffic(8'($urandom), 300, 45, 1'b0);
        wait_idle();

        if (mismatch_count == 0)
            $display("latching_relay_sequencer_core_tb: done, clean");
        else
            $display("latching_relay_sequencer_core_tb: done, errors");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5ms;
        $display("latching_relay_sequencer_core_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/lrs_pkg.sv
src/lrs_queue.sv
src/latching_relay_sequencer_core.sv
tb/latching_relay_sequencer_core_tb.sv
